>>> rtl/frw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frw_pkg
// shared constants, codes and types of the flux histogram reweight block
// ----------------------------------------------------------------------------
package frw_pkg;

   localparam int NUM_BINS_DEF      = 200;
   localparam int BIN_WIDTH_MEV_DEF = 50;
   localparam int MAX_UNIVERSES_DEF = 64;

   // divider geometry
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 6;

   // ratio and weight formats
   localparam int RATIO_W  = 41;
   localparam int SHIFT_W  = 16;
   localparam int PROD_W   = 58;
   localparam int WEIGHT_W = 24;

   localparam logic [RATIO_W-1:0] RATIO_CLAMP = RATIO_W'(1) << 40;
   localparam logic [15:0] ONE_Q12 = 16'd4096;
   localparam logic [WEIGHT_W-1:0] ONE_Q16 = 24'd65536;

   // commands
   localparam logic [1:0] CMD_LOAD_TABLE = 2'd0;
   localparam logic [1:0] CMD_LOAD_SHIFT = 2'd1;
   localparam logic [1:0] CMD_EVENT      = 2'd2;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;

   // result status
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_CVZERO = 3'd1;
   localparam logic [2:0] ST_BADP   = 3'd2;
   localparam logic [2:0] ST_BADF   = 3'd3;
   localparam logic [2:0] ST_BIN    = 3'd4;

   // configuration register indexes
   localparam logic REG_UNIV_COUNT = 1'b0;
   localparam logic REG_SHIFT_MODE = 1'b1;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_BIN   = 9'b000000010,
      S_LOOK  = 9'b000000100,
      S_START = 9'b000001000,
      S_RATIO = 9'b000010000,
      S_SHIFT = 9'b000100000,
      S_MUL   = 9'b001000000,
      S_SAT   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

endpackage
`default_nettype wire

>>> rtl/frw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frw_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module frw_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [frw_pkg::DIV_NUM_W-1:0]  dividend,
   input  wire logic [frw_pkg::DIV_DEN_W-1:0]  divisor,
   output logic                                done,
   output logic      [frw_pkg::DIV_NUM_W-1:0]  quotient
);
   import frw_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0]  dq_ff, dq_in;
   logic [DIV_DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_DEN_W-1:0]  den_ff, den_in;
   logic [DIV_DEN_W:0]    rem_sh;
   logic                  fits;

   assign rem_sh = {rem_ff, dq_ff[DIV_NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         rem_in = fits ? DIV_DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_DEN_W-1:0];
         dq_in  = {dq_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) busy_in = 1'b0;
      end
   end

   // done follows the step that writes the last quotient bit
   assign done_in = busy_ff && !busy_in && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule
`default_nettype wire

>>> rtl/frw_wgt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frw_wgt
// shared multiply and saturate for one universe weight
// ----------------------------------------------------------------------------
module frw_wgt (
   input  wire logic                                clock,
   input  wire logic                                mul_en,
   input  wire logic        [frw_pkg::RATIO_W-1:0]  ratio,
   input  wire logic signed [frw_pkg::SHIFT_W-1:0]  shift,
   output logic signed      [frw_pkg::WEIGHT_W-1:0] weight
);
   import frw_pkg::*;

   logic signed [RATIO_W:0]    diff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   rounded;
   logic signed [PROD_W-13:0]  scaled;
   logic signed [PROD_W-12:0]  wide_w;

   assign diff    = $signed({1'b0, ratio}) - $signed((RATIO_W+1)'(65536));
   assign prod_in = PROD_W'(diff * shift);

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= prod_in;
   end

   // round half up, then back to q8.16 and saturate
   assign rounded = prod_ff + $signed(PROD_W'(2048));
   assign scaled  = rounded[PROD_W-1:12];
   assign wide_w  = (PROD_W-11)'(scaled) + $signed((PROD_W-11)'(65536));

   always_comb begin
      if (wide_w > $signed((PROD_W-11)'(8388607)))
         weight = 24'sh7FFFFF;
      else if (wide_w < -$signed((PROD_W-11)'(8388608)))
         weight = 24'sh800000;
      else
         weight = wide_w[WEIGHT_W-1:0];
   end

endmodule
`default_nettype wire

>>> rtl/flux_histogram_reweight.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flux_histogram_reweight
// per-universe flux weights from central-value and reweight histograms
// ----------------------------------------------------------------------------
// usage
//  - req channel: one transfer per command, tuser carries the command; table
//    loads and shift loads leave req_tready high and give no result
//  - an event transfer gives one rsp transfer per universe (tlast on the
//    final one) or a single error transfer for a bad parent, bad flavour or
//    energy beyond the table
//  - the energy bin comes from a constant reciprocal multiply; one shared
//    48-step divider forms the rw/cv ratio; each universe then passes through
//    shift read, multiply, saturate and output
//  - req_tready stays low after an event transfer until its last result
//    is taken, also when cv is zero, for a bad code and for a bin error
//  - while rsp_tready holds off, the current result is held and nothing
//    is dropped
//  - reset clears the sequencer and sets universe_count 1, shift_mode 0;
//    table and shift memories hold nothing valid until loaded
//  - csr writes act at once, ungated; the user makes them only while idle
// ----------------------------------------------------------------------------
module flux_histogram_reweight
   import frw_pkg::*;
#(
   parameter int NUM_BINS      = NUM_BINS_DEF,
   parameter int BIN_WIDTH_MEV = BIN_WIDTH_MEV_DEF,
   parameter int MAX_UNIVERSES = MAX_UNIVERSES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // parent_code, flavor_code, energy_mev, table_parent, table_flavor,
   // table_bin, cv_value, rw_value, universe_index, shift_value
   input  wire logic [143:0] req_tdata,
   input  wire logic [1:0]   req_tuser,   // cmd
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // universe, weight, zero fill
   output logic [31:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser,   // status
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [6:0]   csr_wdata
);
   localparam int DEPTH = 16 * NUM_BINS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;

   // bin = (energy * recip) >> 24, exact for 14-bit energy and widths to 1000
   localparam logic [24:0] BIN_RECIP = 25'((2**24 + BIN_WIDTH_MEV - 1) / BIN_WIDTH_MEV);

   // request fields
   logic signed [15:0] parent_code, flavor_code, shift_value;
   logic [13:0]        energy_mev;
   logic [1:0]         table_parent, table_flavor;
   logic [7:0]         table_bin;
   logic [31:0]        cv_value, rw_value;
   logic [5:0]         universe_index;

   assign parent_code    = $signed(req_tdata[15:0]);
   assign flavor_code    = $signed(req_tdata[31:16]);
   assign energy_mev     = req_tdata[45:32];
   assign table_parent   = req_tdata[47:46];
   assign table_flavor   = req_tdata[49:48];
   assign table_bin      = req_tdata[57:50];
   assign cv_value       = req_tdata[89:58];
   assign rw_value       = req_tdata[121:90];
   assign universe_index = req_tdata[127:122];
   assign shift_value    = $signed(req_tdata[143:128]);

   state_type state_ff, state_in;

   logic [6:0] univ_count_ff;
   logic       shift_mode_ff;

   // histogram memory: cv in the low word, rw in the high word
   logic [63:0]   hist_mem [DEPTH];
   logic [63:0]   hist_rd_ff;
   logic [AW-1:0] addr_ff, addr_in, load_addr;
   logic [15:0]   shift_mem [MAX_UNIVERSES];
   logic [15:0]   shift_rd_ff;

   logic [3:0]    class_ff, class_in;      // parent and flavour index
   logic [14:0]   bin_ff, bin_in;
   logic [38:0]   bin_prod;
   logic [5:0]    univ_ff, univ_in;
   logic          cvzero_ff, cvzero_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;

   logic [5:0]    r_univ_ff, r_univ_in;
   logic [23:0]   r_weight_ff, r_weight_in;
   logic [2:0]    r_status_ff, r_status_in;
   logic          r_last_ff, r_last_in;

   logic          req_xfer, rsp_xfer;
   logic          p_ok, f_ok;
   logic [1:0]    p_idx, f_idx;
   logic [6:0]    n_eff;
   logic          is_last;

   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_q;
   logic [DIV_DEN_W-1:0] div_den;

   logic signed [SHIFT_W-1:0] mul_shift;
   logic signed [WEIGHT_W-1:0] wgt;

   assign req_tready = state_ff == S_IDLE;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = state_ff == S_OUT;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // parent and flavour code decode
   always_comb begin
      p_ok  = 1'b1;
      p_idx = 2'd0;
      if (parent_code == 16'sd211 || parent_code == -16'sd211)      p_idx = 2'd0;
      else if (parent_code == 16'sd321 || parent_code == -16'sd321) p_idx = 2'd1;
      else if (parent_code == 16'sd130)                             p_idx = 2'd2;
      else if (parent_code == 16'sd13 || parent_code == -16'sd13)   p_idx = 2'd3;
      else p_ok = 1'b0;
      f_ok  = 1'b1;
      f_idx = 2'd0;
      if (flavor_code == 16'sd14)       f_idx = 2'd0;
      else if (flavor_code == -16'sd14) f_idx = 2'd1;
      else if (flavor_code == 16'sd12)  f_idx = 2'd2;
      else if (flavor_code == -16'sd12) f_idx = 2'd3;
      else f_ok = 1'b0;
   end

   // universes per event, zero counts as one, above MAX_UNIVERSES clamps to it
   always_comb begin
      if (univ_count_ff == 7'd0)                        n_eff = 7'd1;
      else if (univ_count_ff > 7'(MAX_UNIVERSES))       n_eff = 7'(MAX_UNIVERSES);
      else                                              n_eff = univ_count_ff;
   end
   assign is_last = (7'(univ_ff) + 7'd1) == n_eff;

   assign load_addr = AW'({table_parent, table_flavor}) * AW'(NUM_BINS) + AW'(table_bin);

   // energy bin by reciprocal multiply
   assign bin_prod = 39'(energy_mev) * 39'(BIN_RECIP);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      class_in    = class_ff;
      bin_in      = bin_ff;
      univ_in     = univ_ff;
      cvzero_in   = cvzero_ff;
      ratio_in    = ratio_ff;
      r_univ_in   = r_univ_ff;
      r_weight_in = r_weight_ff;
      r_status_in = r_status_ff;
      r_last_in   = r_last_ff;
      div_start   = 1'b0;
      div_num     = {hist_rd_ff[63:32], 16'd0};
      div_den     = hist_rd_ff[31:0];
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_tuser == CMD_EVENT) begin
               r_univ_in   = '0;
               r_weight_in = '0;
               r_last_in   = 1'b1;
               class_in    = {p_idx, f_idx};
               bin_in      = bin_prod[38:24];
               if (!p_ok) begin
                  r_status_in = ST_BADP;
                  state_in    = S_OUT;
               end else if (!f_ok) begin
                  r_status_in = ST_BADF;
                  state_in    = S_OUT;
               end else begin
                  state_in = S_BIN;
               end
            end
         end
         S_BIN: begin
            if (bin_ff >= 15'(NUM_BINS)) begin
               r_status_in = ST_BIN;
               state_in    = S_OUT;
            end else begin
               addr_in  = AW'(class_ff) * AW'(NUM_BINS) + AW'(bin_ff);
               state_in = S_LOOK;
            end
         end
         S_LOOK: state_in = S_START;
         S_START: begin
            univ_in   = '0;
            cvzero_in = hist_rd_ff[31:0] == 32'd0;
            if (hist_rd_ff[31:0] == 32'd0) begin
               state_in = S_SHIFT;
            end else begin
               div_start = 1'b1;
               state_in  = S_RATIO;
            end
         end
         S_RATIO: begin
            if (div_done) begin
               ratio_in = (div_q > DIV_NUM_W'(RATIO_CLAMP)) ? RATIO_CLAMP : div_q[RATIO_W-1:0];
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: state_in = S_MUL;
         S_MUL:   state_in = S_SAT;
         S_SAT: begin
            r_univ_in   = univ_ff;
            r_last_in   = is_last;
            r_weight_in = cvzero_ff ? ONE_Q16 : wgt;
            r_status_in = cvzero_ff ? ST_CVZERO : ST_OK;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (rsp_xfer) begin
               if (r_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  univ_in  = univ_ff + 1'b1;
                  state_in = S_SHIFT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign mul_shift = shift_mode_ff ? $signed(shift_rd_ff) : $signed(ONE_Q12);

   frw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   frw_wgt u_wgt (
      .clock  (clock),
      .mul_en (state_ff == S_MUL),
      .ratio  (ratio_ff),
      .shift  (mul_shift),
      .weight (wgt)
   );

   // memories
   always_ff @(posedge clock) begin
      if (req_xfer && req_tuser == CMD_LOAD_TABLE && 11'(table_bin) < 11'(NUM_BINS))
         hist_mem[load_addr] <= {rw_value, cv_value};
      hist_rd_ff <= hist_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (req_xfer && req_tuser == CMD_LOAD_SHIFT && 7'(universe_index) < 7'(MAX_UNIVERSES))
         shift_mem[universe_index[SW-1:0]] <= shift_value;
      shift_rd_ff <= shift_mem[univ_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         univ_count_ff <= 7'd1;
         shift_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == REG_UNIV_COUNT) univ_count_ff <= csr_wdata;
         if (csr_we && csr_index == REG_SHIFT_MODE) shift_mode_ff <= csr_wdata[0];
      end
      addr_ff     <= addr_in;
      class_ff    <= class_in;
      bin_ff      <= bin_in;
      univ_ff     <= univ_in;
      cvzero_ff   <= cvzero_in;
      ratio_ff    <= ratio_in;
      r_univ_ff   <= r_univ_in;
      r_weight_ff <= r_weight_in;
      r_status_ff <= r_status_in;
      r_last_ff   <= r_last_in;
   end

   assign rsp_tdata = {2'b00, r_weight_ff, r_univ_ff};
   assign rsp_tuser = r_status_ff;
   assign rsp_tlast = r_last_ff;

`ifndef SYNTHESIS
   // an accepted event blocks further requests in the next cycle
   a_busy_after_event: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_EVENT |=> !req_tready)
      else $error("request accepted while event in progress");

   // error results are always single and last
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_BADP || rsp_tuser == ST_BADF || rsp_tuser == ST_BIN)
      |-> rsp_tlast && rsp_tdata[5:0] == 6'd0)
      else $error("error result not a single last transfer");

   // results and requests never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request side open while result pending");
`endif

endmodule
`default_nettype wire

>>> test/frw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_checker
// watches the req, rsp and csr ports, predicts the weights of every event and
// compares each rsp transfer with the oldest predicted weight
// ----------------------------------------------------------------------------
module frw_checker
   import frw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [143:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [31:0]  rsp_tdata,
   input  wire logic [2:0]   rsp_tuser,
   input  wire logic         rsp_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [6:0]   csr_wdata,
   output int                fail_count,
   output int                weights_due
);

   typedef struct packed {
      logic [5:0]  universe;
      logic [23:0] weight;
      logic [2:0]  status;
      logic        last;
   } weight_type;

   logic [31:0] cv_mem [0:3199];
   logic [31:0] rw_mem [0:3199];
   logic [15:0] shift_mem [0:63];
   logic [6:0]  univ_count;
   logic        shift_mode;
   weight_type  weights_q[$];

   function automatic weight_type mk(int u, longint w, logic [2:0] st, logic l);
      weight_type r;
      r.universe = u[5:0];
      r.weight   = w[23:0];
      r.status   = st;
      r.last     = l;
      return r;
   endfunction

   // predict the results of one event transfer
   task automatic weigh_event(input logic [143:0] d);
      logic signed [15:0] pc;
      logic signed [15:0] fc;
      int pi, fi, bin, idx, n;
      logic [31:0] cv, rw;
      logic [63:0] q;
      longint ratio, s, t, w;
      pc = d[15:0];
      fc = d[31:16];
      case (pc)
         16'sd211, -16'sd211: pi = 0;
         16'sd321, -16'sd321: pi = 1;
         16'sd130:            pi = 2;
         16'sd13, -16'sd13:   pi = 3;
         default:             pi = -1;
      endcase
      case (fc)
         16'sd14:  fi = 0;
         -16'sd14: fi = 1;
         16'sd12:  fi = 2;
         -16'sd12: fi = 3;
         default:  fi = -1;
      endcase
      bin = int'(d[45:32]) / 50;
      if (pi < 0) begin
         weights_q.push_back(mk(0, 0, ST_BADP, 1'b1));
         return;
      end
      if (fi < 0) begin
         weights_q.push_back(mk(0, 0, ST_BADF, 1'b1));
         return;
      end
      if (bin >= 200) begin
         weights_q.push_back(mk(0, 0, ST_BIN, 1'b1));
         return;
      end
      idx = (pi * 4 + fi) * 200 + bin;
      cv = cv_mem[idx];
      rw = rw_mem[idx];
      n = (univ_count == 0) ? 1 : ((univ_count > 64) ? 64 : int'(univ_count));
      ratio = 0;
      if (cv != 0) begin
         q = {16'd0, rw, 16'd0} / {32'd0, cv};
         ratio = (q > 64'd1 << 40) ? (64'sd1 <<< 40) : longint'(q);
      end
      for (int i = 0; i < n; i++) begin
         if (cv == 0) begin
            weights_q.push_back(mk(i, 65536, ST_CVZERO, i == n - 1));
         end else begin
            s = shift_mode ? longint'($signed(shift_mem[i])) : 64'sd4096;
            t = (ratio - 65536) * s;
            w = 65536 + ((t + 2048) >>> 12);
            if (w > 8388607) w = 8388607;
            if (w < -8388608) w = -8388608;
            weights_q.push_back(mk(i, w, ST_OK, i == n - 1));
         end
      end
   endtask

   always @(posedge clock) begin
      weight_type got, want;
      if (reset) begin
         univ_count  = 7'd1;
         shift_mode  = 1'b0;
         fail_count  = 0;
         weights_due = 0;
         weights_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_UNIV_COUNT) univ_count = csr_wdata;
            else                             shift_mode = csr_wdata[0];
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_LOAD_TABLE: begin
                  if (req_tdata[57:50] < 200) begin
                     cv_mem[(req_tdata[47:46] * 4 + req_tdata[49:48]) * 200
                            + req_tdata[57:50]] = req_tdata[89:58];
                     rw_mem[(req_tdata[47:46] * 4 + req_tdata[49:48]) * 200
                            + req_tdata[57:50]] = req_tdata[121:90];
                  end
               end
               CMD_LOAD_SHIFT: shift_mem[req_tdata[127:122]] = req_tdata[143:128];
               CMD_EVENT:      weigh_event(req_tdata);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = mk(int'(rsp_tdata[5:0]), longint'($signed(rsp_tdata[29:6])), rsp_tuser,
                     rsp_tlast);
            if (weights_q.size() == 0) begin
               $display("%0t: unexpected rsp transfer, expected none, actual %h", $time, got);
               fail_count++;
            end else begin
               want = weights_q.pop_front();
               if (got.universe !== want.universe) begin
                  $display("%0t: universe expected %0d actual %0d", $time,
                           want.universe, got.universe);
                  fail_count++;
               end
               if (got.weight !== want.weight) begin
                  $display("%0t: weight expected %h actual %h", $time,
                           want.weight, got.weight);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time,
                           want.last, got.last);
                  fail_count++;
               end
            end
         end
         weights_due = weights_q.size();
      end
   end

endmodule

>>> test/tb_flux_histogram_reweight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flux_histogram_reweight
// drives table loads, shift loads and events into the reweight block under
// several universe counts and shift modes, with bursty req traffic and a
// stalling rsp side; the checker predicts and compares every weight
// ----------------------------------------------------------------------------
module tb_flux_histogram_reweight;
   import frw_pkg::*;

   logic         clock;
   logic         reset;
   logic [143:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_we;
   logic         csr_index;
   logic [6:0]   csr_wdata;
   int           fail_count;
   int           weights_due;

   // table entries already loaded, the only ones an event may read
   int           loaded_q[$];
   bit           loaded [0:3199];
   int           burst_left = 0;
   int           n_sent = 0;
   longint       cycles = 0;

   flux_histogram_reweight u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   frw_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .weights_due (weights_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 1500000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // rsp side: stretches of always ready, random and mostly stalled, plus one
   // long hold-off once traffic is well under way so the block backs up
   initial begin
      int mode, len;
      bit held;
      held = 0;
      rsp_tready = 1'b0;
      forever begin
         if (!held && n_sent >= 130) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (2000) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         len  = $urandom_range(5, 60);
         repeat (len) begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 5) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // one req transfer; a random gap opens before each new burst
   task automatic send(input logic [1:0] cmd, input logic [143:0] d);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tuser  <= cmd;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      n_sent++;
   endtask

   function automatic logic [143:0] noise();
      return 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
   endfunction

   task automatic load_entry(input int p, input int f, input int b,
                             input logic [31:0] cv, input logic [31:0] rw);
      logic [143:0] d;
      d = noise();
      d[47:46]  = p[1:0];
      d[49:48]  = f[1:0];
      d[57:50]  = b[7:0];
      d[89:58]  = cv;
      d[121:90] = rw;
      send(CMD_LOAD_TABLE, d);
      if (b < 200 && !loaded[(p * 4 + f) * 200 + b]) begin
         loaded[(p * 4 + f) * 200 + b] = 1;
         loaded_q.push_back((p * 4 + f) * 200 + b);
      end
   endtask

   task automatic load_shift(input int u, input logic [15:0] s);
      logic [143:0] d;
      d = noise();
      d[127:122] = u[5:0];
      d[143:128] = s;
      send(CMD_LOAD_SHIFT, d);
   endtask

   task automatic event_raw(input logic [15:0] pc, input logic [15:0] fc,
                            input logic [13:0] e);
      logic [143:0] d;
      d = noise();
      d[15:0]  = pc;
      d[31:16] = fc;
      d[45:32] = e;
      send(CMD_EVENT, d);
   endtask

   // event on a loaded entry, with a random code of the right class
   task automatic event_on(input int idx);
      logic [15:0] pc, fc;
      int p, f, b;
      p = idx / 800;
      f = (idx / 200) % 4;
      b = idx % 200;
      case (p)
         0: pc = $urandom_range(0, 1) ? 16'd211 : -16'sd211;
         1: pc = $urandom_range(0, 1) ? 16'd321 : -16'sd321;
         2: pc = 16'd130;
         default: pc = $urandom_range(0, 1) ? 16'd13 : -16'sd13;
      endcase
      case (f)
         0: fc = 16'd14;
         1: fc = -16'sd14;
         2: fc = 16'd12;
         default: fc = -16'sd12;
      endcase
      event_raw(pc, fc, 14'(b * 50 + $urandom_range(0, 49)));
   endtask

   function automatic logic [31:0] rand_cv();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom_range(1, 1000);
         2: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_rw(input logic [31:0] cv);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'd0;
         default: return cv + $urandom_range(0, 200) - 100;
      endcase
   endfunction

   function automatic logic [15:0] rand_bad_code();
      logic [15:0] c;
      c = 16'($urandom);
      if (c == 16'd14 || c == -16'sd14 || c == 16'd12 || c == -16'sd12 ||
          c == 16'd211 || c == -16'sd211 || c == 16'd321 || c == -16'sd321 ||
          c == 16'd130 || c == 16'd13 || c == -16'sd13)
         c = 16'h8000;
      return c;
   endfunction

   task automatic write_reg(input logic idx, input logic [6:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // sender pauses until every weight is out and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (weights_due != 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic random_item();
      int k, p, f, b;
      logic [31:0] cv;
      k = $urandom_range(0, 99);
      if (k < 12) begin
         p = $urandom_range(0, 3);
         f = $urandom_range(0, 3);
         b = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 199);
         cv = rand_cv();
         load_entry(p, f, b, cv, rand_rw(cv));
      end else if (k < 17) begin
         load_shift($urandom_range(0, 63), 16'($urandom));
      end else if (k < 20) begin
         send(CMD_UNUSED, noise());
      end else if (k < 85) begin
         event_on(loaded_q[$urandom_range(0, loaded_q.size() - 1)]);
      end else if (k < 90) begin
         event_raw(rand_bad_code(), 16'($urandom), 14'($urandom));
      end else if (k < 95) begin
         event_raw($urandom_range(0, 1) ? 16'd130 : -16'sd13, rand_bad_code(),
                   14'($urandom));
      end else begin
         event_raw(16'd211, 16'd14, 14'($urandom_range(10000, 16383)));
      end
   endtask

   initial begin
      logic [6:0] univ_set [0:5];
      logic       mode_set [0:5];
      univ_set = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd17};
      mode_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_LOAD_TABLE;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_UNIV_COUNT;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every shift gets a value before shift mode is ever used
      for (int u = 0; u < 64; u++) begin
         case (u)
            0: load_shift(u, 16'h7FFF);
            1: load_shift(u, 16'h8000);
            2: load_shift(u, 16'h0000);
            3: load_shift(u, 16'd4096);
            default: load_shift(u, 16'($urandom));
         endcase
      end
      drain();
      write_reg(REG_UNIV_COUNT, 7'd4);
      write_reg(REG_SHIFT_MODE, 7'd1);

      // directed: extremes of the tables, every code, bin limits, errors
      load_entry(0, 0, 0, 32'd1, 32'hFFFF_FFFF);
      load_entry(1, 1, 199, 32'hFFFF_FFFF, 32'd0);
      load_entry(2, 2, 10, 32'd0, 32'd1234);
      load_entry(3, 3, 100, 32'd1000, 32'd1500);
      load_entry(0, 3, 5, 32'd65536, 32'd65536);
      load_entry(1, 2, 250, 32'd7, 32'd9);
      send(CMD_UNUSED, noise());
      event_raw(16'd211, 16'd14, 14'd0);
      event_raw(-16'sd211, 16'd14, 14'd49);
      event_raw(16'd321, -16'sd14, 14'd9999);
      event_raw(-16'sd321, -16'sd14, 14'd9950);
      event_raw(16'd130, 16'd12, 14'd500);
      event_raw(16'd13, -16'sd12, 14'd5000);
      event_raw(-16'sd13, -16'sd12, 14'd5049);
      event_raw(16'd211, -16'sd12, 14'd250);
      event_raw(16'd0, 16'd14, 14'd0);
      event_raw(16'hFFFF, 16'd14, 14'd0);
      event_raw(16'd211, 16'd13, 14'd0);
      event_raw(16'd211, 16'h7FFF, 14'd0);
      event_raw(16'd211, 16'd14, 14'd10000);
      event_raw(16'd211, 16'd14, 14'd16383);
      drain();

      // random phases under a range of universe counts and shift modes
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_UNIV_COUNT, univ_set[ph]);
         write_reg(REG_SHIFT_MODE, {6'd0, mode_set[ph]});
         repeat (24) random_item();
         drain();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/frw_pkg.sv
rtl/frw_div.sv
rtl/frw_wgt.sv
rtl/flux_histogram_reweight.sv
test/frw_checker.sv
test/tb_flux_histogram_reweight.sv
